// ===== hw/rtl/mbfl_pkg.sv =====
`timescale 1ns / 1ps

package mbfl_pkg;

  // Widths of the stored time stamp and fault counters.
  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 32;

  // Fixed widths of the stream fields.
  localparam int NOW_W      = 32;
  localparam int OUT_W      = 32;
  localparam int OP_W       = 3;
  localparam int ORIGIN_W   = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 144;

  typedef enum logic [OP_W-1:0] {
    OP_INIT    = 3'd0,
    OP_STARTUP = 3'd1,
    OP_POLL    = 3'd2,
    OP_BREAK   = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [ORIGIN_W-1:0] {
    ORIG_NONE    = 2'd0,
    ORIG_STARTUP = 2'd1,
    ORIG_RUNTIME = 2'd2
  } origin_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [NOW_W-1:0] now_ms;
    logic             primary_break_seen;
    logic             secondary_break_seen;
    logic             break_pin_high;
    logic             start_qualified;
    logic             outside_safe;
    logic             compares_are_zero;
  } item_t;

  typedef struct packed {
    logic               answer_bit;
    logic               output_enable;
    logic               zero_compares;
    logic               fault_latched;
    logic               primary_flag_copy;
    logic               secondary_flag_copy;
    logic [OUT_W-1:0]   primary_fault_count;
    logic [OUT_W-1:0]   secondary_fault_count;
    logic [OUT_W-1:0]   primary_last_time;
    logic [OUT_W-1:0]   secondary_last_time;
    logic [ORIGIN_W-1:0] fault_origin;
    logic               prewake_flag;
  } result_t;

  // Handshake between the two register stages.
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

// ===== hw/rtl/mbfl_in_stage.sv =====
`timescale 1ns / 1ps

module mbfl_in_stage
  import mbfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_item,
  input  logic       advance,
  output stage_ctl_t ctl,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign ctl.valid   = valid_r;
  assign ctl.advance = advance;
  assign item        = item_r;

endmodule

// ===== hw/rtl/mbfl_core.sv =====
`timescale 1ns / 1ps

module mbfl_core
  import mbfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t ctl,
  input  item_t      item,
  output result_t    result
);

  logic                  fire;
  logic                  latched_r, latched_nxt;
  logic                  pflag_r, pflag_nxt;
  logic                  sflag_r, sflag_nxt;
  logic                  enable_r, enable_nxt;
  logic [COUNT_BITS-1:0] pcount_r, pcount_nxt;
  logic [COUNT_BITS-1:0] scount_r, scount_nxt;
  logic [TIME_BITS-1:0]  ptime_r, ptime_nxt;
  logic [TIME_BITS-1:0]  stime_r, stime_nxt;
  origin_t               origin_r, origin_nxt;
  logic                  prewake_r, prewake_nxt;
  logic [TIME_BITS-1:0]  t_ext;
  logic                  do_latch;
  origin_t               latch_why;
  logic                  ans;

  assign fire  = ctl.valid && ctl.advance;
  assign t_ext = TIME_BITS'(item.now_ms);

  // Decide whether this beat latches the fault, and why.
  always_comb begin
    do_latch  = 1'b0;
    latch_why = ORIG_RUNTIME;
    case (item.op)
      OP_STARTUP: begin
        do_latch  = !item.start_qualified || !item.break_pin_high;
        latch_why = ORIG_STARTUP;
      end
      OP_POLL:  do_latch = item.primary_break_seen;
      OP_BREAK: do_latch = 1'b1;
      default:  do_latch = 1'b0;
    endcase
  end

  always_comb begin
    latched_nxt = latched_r;
    pflag_nxt   = pflag_r;
    sflag_nxt   = sflag_r;
    enable_nxt  = enable_r;
    pcount_nxt  = pcount_r;
    scount_nxt  = scount_r;
    ptime_nxt   = ptime_r;
    stime_nxt   = stime_r;
    origin_nxt  = origin_r;
    prewake_nxt = prewake_r;
    ans         = 1'b0;

    if (do_latch) begin
      enable_nxt  = 1'b0;
      pflag_nxt   = 1'b1;
      latched_nxt = 1'b1;
      pcount_nxt  = pcount_r + COUNT_BITS'(1);
      ptime_nxt   = t_ext;
      origin_nxt  = latch_why;
    end

    unique case (item.op)
      OP_INIT: begin
        latched_nxt = 1'b0;
        pflag_nxt   = 1'b0;
        sflag_nxt   = 1'b0;
        enable_nxt  = 1'b0;
        pcount_nxt  = '0;
        scount_nxt  = '0;
        ptime_nxt   = '0;
        stime_nxt   = '0;
        origin_nxt  = ORIG_NONE;
        prewake_nxt = item.primary_break_seen;
      end
      OP_STARTUP: begin
        if (!do_latch) begin
          enable_nxt = 1'b1;
        end
        ans = latched_nxt;
      end
      OP_POLL: begin
        if (item.secondary_break_seen) begin
          scount_nxt = scount_r + COUNT_BITS'(1);
          stime_nxt  = t_ext;
        end
        pflag_nxt = item.primary_break_seen;
        sflag_nxt = item.secondary_break_seen;
        ans       = item.primary_break_seen;
      end
      OP_BREAK: begin
        ans = 1'b0;
      end
      OP_CLEAR: begin
        if (item.outside_safe && item.break_pin_high && item.compares_are_zero) begin
          pflag_nxt   = 1'b0;
          latched_nxt = 1'b0;
          enable_nxt  = 1'b1;
          ans         = 1'b1;
        end
      end
      default: begin
        ans = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r <= 1'b0;
      pflag_r   <= 1'b0;
      sflag_r   <= 1'b0;
      enable_r  <= 1'b0;
      pcount_r  <= '0;
      scount_r  <= '0;
      ptime_r   <= '0;
      stime_r   <= '0;
      origin_r  <= ORIG_NONE;
      prewake_r <= 1'b0;
    end else if (fire) begin
      latched_r <= latched_nxt;
      pflag_r   <= pflag_nxt;
      sflag_r   <= sflag_nxt;
      enable_r  <= enable_nxt;
      pcount_r  <= pcount_nxt;
      scount_r  <= scount_nxt;
      ptime_r   <= ptime_nxt;
      stime_r   <= stime_nxt;
      origin_r  <= origin_nxt;
      prewake_r <= prewake_nxt;
    end
  end

  always_comb begin
    result.answer_bit            = ans;
    result.output_enable         = enable_nxt;
    result.zero_compares         = do_latch;
    result.fault_latched         = latched_nxt;
    result.primary_flag_copy     = pflag_nxt;
    result.secondary_flag_copy   = sflag_nxt;
    result.primary_fault_count   = OUT_W'(pcount_nxt);
    result.secondary_fault_count = OUT_W'(scount_nxt);
    result.primary_last_time     = OUT_W'(ptime_nxt);
    result.secondary_last_time   = OUT_W'(stime_nxt);
    result.fault_origin          = origin_nxt;
    result.prewake_flag          = prewake_nxt;
  end

  // A compare-zero request only ever comes with the latch set and the stage disabled.
  a_zero_implies_latch : assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.zero_compares |-> result.fault_latched && !result.output_enable)
    else $error("zero request without latched fault");

  a_break_latches : assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.op == OP_BREAK |=> latched_r && !enable_r && origin_r == ORIG_RUNTIME)
    else $error("runtime break did not latch");

  a_init_clears : assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.op == OP_INIT |=> pcount_r == '0 && scount_r == '0 && !latched_r)
    else $error("init left counters or latch set");

  a_state_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(latched_r) && $stable(pcount_r) && $stable(scount_r))
    else $error("fault state changed without a beat");

endmodule

// ===== hw/rtl/mbfl_out_stage.sv =====
`timescale 1ns / 1ps

module mbfl_out_stage
  import mbfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t ctl,
  input  result_t    result,
  output logic       advance,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_result
);

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  assign advance   = !valid_r || out_ready;
  assign valid_nxt = advance ? ctl.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid && advance) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ===== hw/rtl/motor_break_fault_latch.sv =====
`timescale 1ns / 1ps
// A beat accepted on the input is held in the input register, passes through the
// core and is held in the result register, from which it is offered on the output.
// Throughput: one beat per cycle without stalls; the input and result registers let
// a new event enter while the previous result still waits for the consumer.
// Reset (rst_n low, synchronous): both stages empty, latch, flags, counters, stamps,
// origin and pre-wake flag cleared, output enable driven low.
module motor_break_fault_latch
  import mbfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata from bit 0: now_ms[31:0], primary_break_seen, secondary_break_seen,
  // break_pin_high, start_qualified, outside_safe, compares_are_zero, 2 zero bits
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: op[2:0]
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata from bit 0: answer_bit, output_enable, zero_compares, fault_latched,
  // primary_flag_copy, secondary_flag_copy, primary_fault_count[31:0],
  // secondary_fault_count[31:0], primary_last_time[31:0], secondary_last_time[31:0],
  // fault_origin[1:0], prewake_flag, 7 zero bits
  output logic [OUT_DATA_W-1:0] out_tdata
);

  item_t      in_item;
  item_t      item;
  stage_ctl_t ctl;
  logic       advance;
  result_t    result;
  result_t    out_result;

  // Unpack the incoming beat into the event record.
  always_comb begin
    in_item.op                   = in_tuser;
    in_item.now_ms               = in_tdata[NOW_W-1:0];
    in_item.primary_break_seen   = in_tdata[NOW_W];
    in_item.secondary_break_seen = in_tdata[NOW_W+1];
    in_item.break_pin_high       = in_tdata[NOW_W+2];
    in_item.start_qualified      = in_tdata[NOW_W+3];
    in_item.outside_safe         = in_tdata[NOW_W+4];
    in_item.compares_are_zero    = in_tdata[NOW_W+5];
  end

  // First stage: holds the accepted event.
  mbfl_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .advance  (advance),
    .ctl      (ctl),
    .item     (item)
  );

  // Fault state and the event decode; state commits as the event moves on.
  mbfl_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .item   (item),
    .result (result)
  );

  // Second stage: the result register towards the consumer.
  mbfl_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  // Pack the result beat, first field in the lowest bit.
  assign out_tdata = {
    7'd0,
    out_result.prewake_flag,
    out_result.fault_origin,
    out_result.secondary_last_time,
    out_result.primary_last_time,
    out_result.secondary_fault_count,
    out_result.primary_fault_count,
    out_result.secondary_flag_copy,
    out_result.primary_flag_copy,
    out_result.fault_latched,
    out_result.zero_compares,
    out_result.output_enable,
    out_result.answer_bit
  };

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mbfl_pkg::*;

  // Op codes that the block does not use. They must leave every register alone.
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // Flag bits as they sit in in_tdata above now_ms, lowest bit first.
  localparam logic [5:0] NO_FLAGS       = 6'b000000;
  localparam logic [5:0] FLAG_PRIMARY   = 6'b000001;
  localparam logic [5:0] FLAG_SECONDARY = 6'b000010;
  localparam logic [5:0] FLAG_PIN_HIGH  = 6'b000100;
  localparam logic [5:0] FLAG_QUALIFIED = 6'b001000;
  localparam logic [5:0] FLAG_SAFE      = 6'b010000;
  localparam logic [5:0] FLAG_CMP_ZERO  = 6'b100000;
  localparam logic [5:0] ALL_FLAGS      = 6'b111111;
  localparam logic [5:0] CLEAR_OK       = FLAG_SAFE | FLAG_PIN_HIGH | FLAG_CMP_ZERO;
  localparam logic [5:0] START_OK       = FLAG_PIN_HIGH | FLAG_QUALIFIED;

  localparam int RANDOM_EVENTS = 830;
  localparam int HOLD_OFF_AT   = 400;  // beats sent before the long receiver hold-off
  localparam int HOLD_OFF_LEN  = 300;  // cycles that the receiver then refuses results
  localparam int SETTLE_CYCLES = 8;
  // The longest quiet stretch in a correct run is the hold-off plus one long sender gap.
  localparam int QUIET_LIMIT   = 2000;

  localparam result_t NO_WANT = '0;

  // One row of the directed table. Where typed is set, want is the result that the
  // block must return; otherwise the predictor supplies the expectation.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [31:0]     now_ms;
    logic [5:0]      flags;
    logic            typed;
    result_t         want;
  } plan_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Shadow copy of the latch state, advanced once per accepted input beat.
  logic        latch_q    = 1'b0;
  logic        pflag_q    = 1'b0;
  logic        sflag_q    = 1'b0;
  logic        enable_q   = 1'b0;
  logic [31:0] pcount_q   = '0;
  logic [31:0] scount_q   = '0;
  logic [31:0] ptime_q    = '0;
  logic [31:0] stime_q    = '0;
  origin_t     origin_q   = ORIG_NONE;
  logic        prewake_q  = 1'b0;

  result_t     pending_status[$];
  plan_row_t   plan[$];
  int          mismatches   = 0;
  int          events_sent  = 0;
  int          calm_items   = 0;
  int          quiet_cycles = 0;
  bit          held_off     = 1'b0;

  always #6 clk = ~clk;

  motor_break_fault_latch dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // A result in which only the answer, the enable and the pre-wake flag may be set,
  // as seen straight after an init or a clean startup.
  function automatic result_t quiet_result(input logic ans, input logic en,
                                           input logic prewake);
    result_t r;
    r               = '0;
    r.answer_bit    = ans;
    r.output_enable = en;
    r.prewake_flag  = prewake;
    return r;
  endfunction

  // Most gaps are short, a few are long.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic latch_fault(input origin_t why, input logic [31:0] now_ms);
    enable_q = 1'b0;
    pflag_q  = 1'b1;
    latch_q  = 1'b1;
    pcount_q = pcount_q + 32'd1;
    ptime_q  = now_ms;
    origin_q = why;
  endtask

  // Advances the shadow state by one event and returns the status beat it must cause.
  task automatic predict_break_latch(input logic [OP_W-1:0] op, input logic [31:0] now_ms,
                                     input logic [5:0] flags, output result_t r);
    logic pbrk, sbrk, pin, qual, safe, czero;
    logic ans, zpulse;
    {czero, safe, qual, pin, sbrk, pbrk} = flags;
    ans    = 1'b0;
    zpulse = 1'b0;
    case (op)
      OP_INIT: begin
        latch_q   = 1'b0;
        pflag_q   = 1'b0;
        sflag_q   = 1'b0;
        enable_q  = 1'b0;
        pcount_q  = '0;
        scount_q  = '0;
        ptime_q   = '0;
        stime_q   = '0;
        origin_q  = ORIG_NONE;
        prewake_q = pbrk;
      end
      OP_STARTUP: begin
        // An unqualified start or a low break pin is treated as a startup timeout.
        if (!qual || !pin) begin
          latch_fault(ORIG_STARTUP, now_ms);
          zpulse = 1'b1;
        end else begin
          enable_q = 1'b1;
        end
        ans = latch_q;
      end
      OP_POLL: begin
        if (pbrk) begin
          latch_fault(ORIG_RUNTIME, now_ms);
          zpulse = 1'b1;
        end
        if (sbrk) begin
          scount_q = scount_q + 32'd1;
          stime_q  = now_ms;
        end
        // The recorded flags follow this poll, even after a latch above.
        pflag_q = pbrk;
        sflag_q = sbrk;
        ans     = pbrk;
      end
      OP_BREAK: begin
        latch_fault(ORIG_RUNTIME, now_ms);
        zpulse = 1'b1;
      end
      OP_CLEAR: begin
        if (safe && pin && czero) begin
          pflag_q  = 1'b0;
          latch_q  = 1'b0;
          enable_q = 1'b1;
          ans      = 1'b1;
        end
      end
      default: ;
    endcase
    r.answer_bit            = ans;
    r.output_enable         = enable_q;
    r.zero_compares         = zpulse;
    r.fault_latched         = latch_q;
    r.primary_flag_copy     = pflag_q;
    r.secondary_flag_copy   = sflag_q;
    r.primary_fault_count   = pcount_q;
    r.secondary_fault_count = scount_q;
    r.primary_last_time     = ptime_q;
    r.secondary_last_time   = stime_q;
    r.fault_origin          = origin_q;
    r.prewake_flag          = prewake_q;
  endtask

  // Offers one event beat, entered and left at a falling edge. A zero gap keeps
  // in_tvalid high across beats without dropping it in between.
  task automatic offer_event(input logic [OP_W-1:0] op, input logic [31:0] now_ms,
                             input logic [5:0] flags, input logic typed,
                             input result_t want);
    int unsigned gap;
    result_t     predicted;
    if (calm_items > 0) begin
      calm_items--;
      gap = 0;
    end else begin
      gap = idle_length();
      if ($urandom_range(0, 39) == 0) calm_items = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, flags, now_ms};
    do @(posedge clk); while (!in_tready);
    predict_break_latch(op, now_ms, flags, predicted);
    pending_status.push_back(typed ? want : predicted);
    events_sent++;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: random stalls, calm stretches with none, and one long hold-off while
  // the sender keeps going, so that both register stages fill and in_tready drops.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned calm_cycles;
    stall_left  = 0;
    calm_cycles = 0;
    forever begin
      @(negedge clk);
      if (!held_off && events_sent >= HOLD_OFF_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(negedge clk);
        held_off = 1'b1;
      end
      if (calm_cycles > 0) begin
        calm_cycles--;
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        stall_left = idle_length();
        if ($urandom_range(0, 63) == 0) calm_cycles = $urandom_range(30, 120);
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Every status beat is compared field by field with the oldest expectation.
  always @(posedge clk) begin : status_check
    result_t seen;
    result_t owed;
    if (rst_n && out_tvalid && out_tready) begin
      seen.answer_bit            = out_tdata[0];
      seen.output_enable         = out_tdata[1];
      seen.zero_compares         = out_tdata[2];
      seen.fault_latched         = out_tdata[3];
      seen.primary_flag_copy     = out_tdata[4];
      seen.secondary_flag_copy   = out_tdata[5];
      seen.primary_fault_count   = out_tdata[37:6];
      seen.secondary_fault_count = out_tdata[69:38];
      seen.primary_last_time     = out_tdata[101:70];
      seen.secondary_last_time   = out_tdata[133:102];
      seen.fault_origin          = out_tdata[135:134];
      seen.prewake_flag          = out_tdata[136];
      if (pending_status.size() == 0) begin
        $error("status beat arrived with nothing outstanding");
        mismatches++;
      end else begin
        owed = pending_status.pop_front();
        check_field("answer_bit", 32'(owed.answer_bit), 32'(seen.answer_bit));
        check_field("output_enable", 32'(owed.output_enable),
                    32'(seen.output_enable));
        check_field("zero_compares", 32'(owed.zero_compares),
                    32'(seen.zero_compares));
        check_field("fault_latched", 32'(owed.fault_latched),
                    32'(seen.fault_latched));
        check_field("primary_flag_copy", 32'(owed.primary_flag_copy),
                    32'(seen.primary_flag_copy));
        check_field("secondary_flag_copy", 32'(owed.secondary_flag_copy),
                    32'(seen.secondary_flag_copy));
        check_field("primary_fault_count", owed.primary_fault_count,
                    seen.primary_fault_count);
        check_field("secondary_fault_count", owed.secondary_fault_count,
                    seen.secondary_fault_count);
        check_field("primary_last_time", owed.primary_last_time,
                    seen.primary_last_time);
        check_field("secondary_last_time", owed.secondary_last_time,
                    seen.secondary_last_time);
        check_field("fault_origin", 32'(owed.fault_origin), 32'(seen.fault_origin));
        check_field("prewake_flag", 32'(owed.prewake_flag), 32'(seen.prewake_flag));
      end
    end
  end

  // Watchdog: a run in which no beat moves on either side for too long is hung.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned      roll;
    logic [OP_W-1:0]  op;
    logic [5:0]       flags;
    logic [31:0]      ms_clock;

    // Directed part: extremes of the time stamp, every op, each failing clear
    // condition, a qualified start while latched, both startup timeout causes,
    // the spare op codes, and init with and without the primary flag set.
    plan.push_back('{OP_INIT,    32'd0,          NO_FLAGS, 1'b1,
                     quiet_result(1'b0, 1'b0, 1'b0)});
    plan.push_back('{OP_POLL,    32'd0,          NO_FLAGS, 1'b1,
                     quiet_result(1'b0, 1'b0, 1'b0)});
    plan.push_back('{OP_STARTUP, 32'd5,          START_OK, 1'b1,
                     quiet_result(1'b0, 1'b1, 1'b0)});
    plan.push_back('{OP_POLL,    32'hFFFF_FFFF,  FLAG_PRIMARY | FLAG_SECONDARY, 1'b0,
                     NO_WANT});
    plan.push_back('{OP_CLEAR,   32'd10,         FLAG_PIN_HIGH | FLAG_CMP_ZERO, 1'b0,
                     NO_WANT});
    plan.push_back('{OP_CLEAR,   32'd11,         FLAG_SAFE | FLAG_CMP_ZERO, 1'b0, NO_WANT});
    plan.push_back('{OP_CLEAR,   32'd12,         FLAG_SAFE | FLAG_PIN_HIGH, 1'b0, NO_WANT});
    plan.push_back('{OP_CLEAR,   32'd13,         CLEAR_OK, 1'b0, NO_WANT});
    plan.push_back('{OP_BREAK,   32'h8000_0000,  ALL_FLAGS, 1'b0, NO_WANT});
    plan.push_back('{OP_STARTUP, 32'd20,         START_OK, 1'b0, NO_WANT});
    plan.push_back('{OP_CLEAR,   32'd21,         CLEAR_OK, 1'b0, NO_WANT});
    plan.push_back('{OP_STARTUP, 32'h7FFF_FFFF,  FLAG_PIN_HIGH, 1'b0, NO_WANT});
    plan.push_back('{OP_CLEAR,   32'd30,         ALL_FLAGS, 1'b0, NO_WANT});
    plan.push_back('{OP_STARTUP, 32'd1,          FLAG_QUALIFIED, 1'b0, NO_WANT});
    plan.push_back('{OP_SPARE_5, 32'hFFFF_FFFF,  ALL_FLAGS, 1'b0, NO_WANT});
    plan.push_back('{OP_SPARE_5 + 3'd1, 32'd40,  ALL_FLAGS, 1'b0, NO_WANT});
    plan.push_back('{OP_SPARE_7, 32'd41,         ALL_FLAGS, 1'b0, NO_WANT});
    plan.push_back('{OP_POLL,    32'h5555_5555,  FLAG_SECONDARY, 1'b0, NO_WANT});
    plan.push_back('{OP_POLL,    32'd50,         NO_FLAGS, 1'b0, NO_WANT});
    plan.push_back('{OP_POLL,    32'hAAAA_AAAA,  FLAG_PRIMARY, 1'b0, NO_WANT});
    plan.push_back('{OP_INIT,    32'd60,         FLAG_PRIMARY, 1'b1,
                     quiet_result(1'b0, 1'b0, 1'b1)});
    plan.push_back('{OP_POLL,    32'd61,         NO_FLAGS, 1'b1,
                     quiet_result(1'b0, 1'b0, 1'b1)});
    plan.push_back('{OP_BREAK,   32'd0,          NO_FLAGS, 1'b0, NO_WANT});
    plan.push_back('{OP_INIT,    32'd70,         NO_FLAGS, 1'b1,
                     quiet_result(1'b0, 1'b0, 1'b0)});

    // Synchronous reset, held low from the start and released between edges.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i])
      offer_event(plan[i].op, plan[i].now_ms, plan[i].flags, plan[i].typed, plan[i].want);

    // Random part. Time mostly creeps forward so that stamps look realistic, with
    // occasional jumps anywhere in the 32-bit range. Clears and startups lean
    // towards the conditions that succeed, so that latches get released again.
    ms_clock = 32'd100;
    repeat (RANDOM_EVENTS) begin
      roll = $urandom_range(0, 99);
      if (roll < 6)       op = OP_INIT;
      else if (roll < 20) op = OP_STARTUP;
      else if (roll < 55) op = OP_POLL;
      else if (roll < 65) op = OP_BREAK;
      else if (roll < 92) op = OP_CLEAR;
      else                op = OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      flags = 6'($urandom);
      case (op)
        OP_CLEAR:   if ($urandom_range(0, 1) != 0) flags = flags | CLEAR_OK;
        OP_STARTUP: if ($urandom_range(0, 2) != 0) flags = flags | START_OK;
        OP_POLL: begin
          flags = flags & ~(FLAG_PRIMARY | FLAG_SECONDARY);
          if ($urandom_range(0, 3) == 0) flags = flags | FLAG_PRIMARY;
          if ($urandom_range(0, 2) == 0) flags = flags | FLAG_SECONDARY;
        end
        default: ;
      endcase
      if ($urandom_range(0, 7) == 0) ms_clock = $urandom;
      else                           ms_clock = ms_clock + $urandom_range(0, 40);
      offer_event(op, ms_clock, flags, 1'b0, NO_WANT);
    end
    in_tvalid <= 1'b0;

    // Drain: the watchdog covers a block that never delivers what is owed.
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
